// ===== design/macl_pkg.sv =====
// Shared types and constants for the MAC allow/deny list filter.
// Used by macl_ctrl and the top level; no dependencies.
`default_nettype none

package macl_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAC_W       = 48;
  localparam int OP_W        = 2;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  // item operation codes; code 3 is unused and answers all zero
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_CHECK = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLED = 1'd0,
    CFG_DENY_LIST_MODE = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic filter_enabled;
    logic deny_list_mode;
  } cfg_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/macl_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module macl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/macl_ctrl.sv =====
// Sequencer for the MAC filter: entry count, table append, linear scan over
// the address RAM and the result register. Depends on macl_pkg.
`default_nettype none

module macl_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire macl_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [macl_pkg::OP_W-1:0]     in_op,
  input  wire logic [macl_pkg::MAC_W-1:0]    in_mac,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_allowed,
  output logic                               out_matched,
  output logic                               out_table_full,
  output macl_pkg::stat_t                    stat,
  output logic                               ram_we,
  output logic [macl_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [macl_pkg::MAC_W-1:0]         ram_wdata,
  output logic                               ram_re,
  output logic [macl_pkg::ADDR_W-1:0]        ram_raddr,
  input  wire logic [macl_pkg::MAC_W-1:0]    ram_rdata
);

  import macl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUB
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             hit_r, hit_nxt;
  logic             full_r, full_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_allowed_r, out_allowed_nxt;
  logic             out_matched_r, out_matched_nxt;
  logic             out_full_r, out_full_nxt;

  logic accept;
  logic pub_ok;
  logic res_allowed, res_matched, res_full;

  assign in_ready       = (state_r == ST_IDLE);
  assign accept         = in_valid && in_ready;
  assign pub_ok         = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_allowed    = out_allowed_r;
  assign out_matched    = out_matched_r;
  assign out_table_full = out_full_r;
  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.count     = count_r;

  // verdict; the user must hold config stable while an item is in flight; the block itself does not enforce it
  always_comb begin
    res_allowed = 1'b0;
    res_matched = 1'b0;
    res_full    = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        res_full = full_r;
      end
      OP_CHECK: begin
        if (!cfg.filter_enabled) begin
          res_allowed = 1'b1;
        end else begin
          res_matched = hit_r;
          res_allowed = cfg.deny_list_mode ? !hit_r : hit_r;
        end
      end
      default: begin
        res_allowed = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    hit_nxt         = hit_r;
    full_nxt        = full_r;
    op_nxt          = op_r;
    mac_nxt         = mac_r;
    out_valid_nxt   = out_valid_r;
    out_allowed_nxt = out_allowed_r;
    out_matched_nxt = out_matched_r;
    out_full_nxt    = out_full_r;
    ram_we          = 1'b0;
    ram_waddr       = count_r[ADDR_W-1:0];
    ram_wdata       = in_mac;
    ram_re          = 1'b0;
    ram_raddr       = idx_r[ADDR_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          mac_nxt   = in_mac;
          hit_nxt   = 1'b0;
          full_nxt  = 1'b0;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_PUB;
          priority if (in_op == OP_CLEAR) begin
            count_nxt = '0;
          end else if (in_op == OP_ADD) begin
            if (count_r == CNT_W'(TABLE_DEPTH)) begin
              full_nxt = 1'b1;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (in_op == OP_CHECK && cfg.filter_enabled && count_r != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, each compared against the registered read data in the next cycle
        if (idx_r < count_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && ram_rdata == mac_r) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_PUB;
        end else if (pend_r && idx_r == count_r) begin
          state_nxt = ST_PUB;
        end
      end
      ST_PUB: begin
        if (pub_ok) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = res_allowed;
          out_matched_nxt = res_matched;
          out_full_nxt    = res_full;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    hit_r         <= hit_nxt;
    full_r        <= full_nxt;
    op_r          <= op_nxt;
    mac_r         <= mac_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_matched_r <= out_matched_nxt;
    out_full_r    <= out_full_nxt;
  end

endmodule

`default_nettype wire

// ===== design/mac_allow_deny_list_filter.sv =====
// MAC allow/deny list filter. One item at a time: a clear or an add passes
// straight to the publish state; a check with filtering enabled walks the
// stored entries through the single read port of the address RAM, one entry
// per cycle, and stops early on the first match. A new item is taken once the
// previous result has been loaded into the output register. Appends write
// the RAM at the accept cycle and scans only read it afterwards, so the two
// never touch the same entry at once. Depends on macl_pkg, macl_ctrl and
// macl_ram.
`default_nettype none

module mac_allow_deny_list_filter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [macl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [macl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [macl_pkg::OP_W-1:0]         in_op,
  input  wire logic [macl_pkg::MAC_W-1:0]        in_mac,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_allowed,
  output logic                                   out_matched,
  output logic                                   out_table_full
);

  import macl_pkg::*;

  cfg_t               cfg_r;
  stat_t              stat;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [MAC_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [MAC_W-1:0]   ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_ENABLED: cfg_r.filter_enabled <= cfg_wdata[0];
        CFG_DENY_LIST_MODE: cfg_r.deny_list_mode <= cfg_wdata[0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  macl_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_mac         (in_mac),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_allowed    (out_allowed),
    .out_matched    (out_matched),
    .out_table_full (out_table_full),
    .stat           (stat),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  macl_ram #(
    .WIDTH (MAC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_CLEAR) |=> stat.count == '0)
    else $error("clear did not empty the table");

  a_full_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (!out_allowed && !out_matched))
    else $error("table_full set on a check result");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.busy)
    else $error("input taken while an item is in flight");
`endif

endmodule

`default_nettype wire
